// ===== hdl/tet_pkg.sv =====
`timescale 1ns / 1ps
package tet_pkg;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] lin_z;
    logic signed [31:0] angle;
  } twist_t;

  typedef struct packed {
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } xform_t;

  localparam int CW = 36;
  typedef logic signed [CW-1:0] cv_t;
  typedef logic signed [79:0] wide_t;
  typedef logic signed [31:0] q32_t;

  // [w]^2 is symmetric: three diagonal and three off-diagonal entries
  typedef struct packed {
    q32_t d0;
    q32_t d1;
    q32_t d2;
    q32_t xy;
    q32_t xz;
    q32_t yz;
  } sq_t;

  typedef struct packed {
    twist_t tw;
    cv_t    s;
    cv_t    oc;
    cv_t    qs;
    sq_t    sq;
    q32_t   a0;
    q32_t   a1;
    q32_t   a2;
    q32_t   b0;
    q32_t   b1;
    q32_t   b2;
  } mat_t;

  localparam cv_t FX_PI      = 36'sd843314857;
  localparam cv_t FX_TWO_PI  = 36'sd1686629713;
  localparam cv_t FX_HALF_PI = 36'sd421657428;
  localparam cv_t FX_GAIN    = 36'sd652032874;
  localparam cv_t FX_ONE30   = 36'sd1073741824;
  localparam wide_t FX_ONE29 = 80'sd536870912;

  localparam cv_t ATAN [32] = '{
    36'sh3243F6A8, 36'sh1DAC6705, 36'sh0FADBAFC, 36'sh07F56EA6, 36'sh03FEAB76,
    36'sh01FFD55B, 36'sh00FFFAAA, 36'sh007FFF55, 36'sh003FFFEA, 36'sh001FFFFD,
    36'sh000FFFFF, 36'sh0007FFFF, 36'sh0003FFFF, 36'sh0001FFFF, 36'sh0000FFFF,
    36'sh00007FFF, 36'sh00003FFF, 36'sh00001FFF, 36'sh00000FFF, 36'sh000007FF,
    36'sh000003FF, 36'sh000001FF, 36'sh000000FF, 36'sh0000007F, 36'sh0000003F,
    36'sh0000001F, 36'sh0000000F, 36'sh00000008, 36'sh00000004, 36'sh00000002,
    36'sh00000001, 36'sh00000000
  };

  // round half up, then drop n fraction bits
  function automatic wide_t rnd(input wide_t x, input int n);
    rnd = (x + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic q32_t sat32(input wide_t x);
    if (x > wide_t'(64'sd2147483647)) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (x < wide_t'(-64'sd2147483648)) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

// ===== hdl/tet_stream_if.sv =====
`timescale 1ns / 1ps
interface tet_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/twist_exponential_transform.sv =====
`timescale 1ns / 1ps
// Twist exponential: takes a screw twist (axis, linear part, angle) and returns
// the rotation and translation rows of exp([xi] q). Fully pipelined: a new
// twist is taken every cycle, and each result passes two angle reduction
// stages, one stage per CORDIC iteration, four matrix stages and two output
// product/sum stages. A two-entry output queue lets the pipeline keep taking
// twists while a result waits; the whole pipeline holds only when that queue
// is full.
module twist_exponential_transform import tet_pkg::*; #(
  parameter int CORDIC_STEPS = 28
) (
  input logic         clk,
  input logic         rst,
  tet_stream_if.sink   twist,
  tet_stream_if.source xform
);

  logic   en;
  logic   cv;
  twist_t ctw;
  cv_t    csin, ccos;
  logic   mv;
  mat_t   mm;
  logic   fv;
  xform_t fx;

  xform_t     qbuf [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign en          = (cnt != 2'd2);
  assign twist.ready = en;

  tet_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .en,
    .in_vld (twist.valid),
    .in_tw  (twist.data),
    .out_vld(cv),
    .out_tw (ctw),
    .sin_v  (csin),
    .cos_v  (ccos)
  );

  tet_mat u_mat (
    .clk, .rst, .en,
    .in_vld (cv),
    .in_tw  (ctw),
    .in_s   (csin),
    .in_c   (ccos),
    .out_vld(mv),
    .out_m  (mm)
  );

  tet_fin u_fin (
    .clk, .rst, .en,
    .in_vld (mv),
    .in_m   (mm),
    .out_vld(fv),
    .out_x  (fx)
  );

  assign push = en && fv;
  assign pop  = xform.valid && xform.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) begin
      qbuf[wp] <= fx;
    end
  end

  assign xform.valid = (cnt != 2'd0);
  assign xform.data  = qbuf[rp];

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue count out of range");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) |-> !twist.ready)
    else $error("input taken while output queue full");

  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (cnt == $past(cnt) + 2'd1))
    else $error("queue count lost a transfer");

endmodule

// ===== hdl/tet_cordic.sv =====
`timescale 1ns / 1ps
module tet_cordic import tet_pkg::*; #(
  parameter int STEPS = 28
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_vld,
  input  twist_t in_tw,
  output logic   out_vld,
  output twist_t out_tw,
  output cv_t    sin_v,
  output cv_t    cos_v
);

  logic   vr1;
  twist_t tw1;
  cv_t    r1;
  cv_t    q0;
  cv_t    r2_next;
  logic   flip_next;

  logic   vs [STEPS+1];
  twist_t tws [STEPS+1];
  logic   flips [STEPS+1];
  cv_t    xs [STEPS+1];
  cv_t    ys [STEPS+1];
  cv_t    zs [STEPS+1];

  assign q0 = CW'(in_tw.angle);

  // first wrap into [-pi, pi]
  always_ff @(posedge clk) begin
    if (rst) begin
      vr1 <= 1'b0;
    end else if (en) begin
      vr1 <= in_vld;
    end
    if (en) begin
      tw1 <= in_tw;
      if (q0 > FX_PI) begin
        r1 <= q0 - FX_TWO_PI;
      end else if (q0 < -FX_PI) begin
        r1 <= q0 + FX_TWO_PI;
      end else begin
        r1 <= q0;
      end
    end
  end

  // fold into [-pi/2, pi/2]; sin and cos change sign
  always_comb begin
    flip_next = 1'b0;
    r2_next   = r1;
    if (r1 > FX_HALF_PI) begin
      r2_next   = r1 - FX_PI;
      flip_next = 1'b1;
    end else if (r1 < -FX_HALF_PI) begin
      r2_next   = r1 + FX_PI;
      flip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= vr1;
    end
    if (en) begin
      tws[0]   <= tw1;
      flips[0] <= flip_next;
      xs[0]    <= FX_GAIN;
      ys[0]    <= '0;
      zs[0]    <= r2_next <<< 2;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
      if (en) begin
        tws[i+1]   <= tws[i];
        flips[i+1] <= flips[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN[i];
        end
      end
    end
  end

  assign out_vld = vs[STEPS];
  assign out_tw  = tws[STEPS];
  assign sin_v   = flips[STEPS] ? -ys[STEPS] : ys[STEPS];
  assign cos_v   = flips[STEPS] ? -xs[STEPS] : xs[STEPS];

endmodule

// ===== hdl/tet_mat.sv =====
`timescale 1ns / 1ps
module tet_mat import tet_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_vld,
  input  twist_t in_tw,
  input  cv_t    in_s,
  input  cv_t    in_c,
  output logic   out_vld,
  output mat_t   out_m
);

  logic signed [32:0] nwx, nwy, nwz;

  logic   v1, v2, v3;
  twist_t tw1, tw2, tw3;
  cv_t    s1, s2, s3, c1, c2, c3;
  logic signed [63:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [64:0] k0a, k0b, k1a, k1b, k2a, k2b;
  sq_t    sq2, sq3;
  q32_t   a0_2, a1_2, a2_2, a0_3, a1_3, a2_3;
  logic signed [63:0] bp00, bp01, bp02, bp10, bp11, bp12, bp20, bp21, bp22;

  assign nwx = -33'(in_tw.axis_x);
  assign nwy = -33'(in_tw.axis_y);
  assign nwz = -33'(in_tw.axis_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      out_vld <= v3;
    end
    if (en) begin
      // products of axis pairs and of [w] rows with v
      tw1 <= in_tw;
      s1  <= in_s;
      c1  <= in_c;
      pxx <= in_tw.axis_x * in_tw.axis_x;
      pyy <= in_tw.axis_y * in_tw.axis_y;
      pzz <= in_tw.axis_z * in_tw.axis_z;
      pxy <= in_tw.axis_x * in_tw.axis_y;
      pxz <= in_tw.axis_x * in_tw.axis_z;
      pyz <= in_tw.axis_y * in_tw.axis_z;
      k0a <= nwz * in_tw.lin_y;
      k0b <= in_tw.axis_y * in_tw.lin_z;
      k1a <= in_tw.axis_z * in_tw.lin_x;
      k1b <= nwx * in_tw.lin_z;
      k2a <= nwy * in_tw.lin_x;
      k2b <= in_tw.axis_x * in_tw.lin_y;

      // [w]^2 and A = [w] v
      tw2 <= tw1;
      s2  <= s1;
      c2  <= c1;
      sq2.d0 <= sat32(rnd(-wide_t'(pzz), 29) + rnd(-wide_t'(pyy), 29));
      sq2.d1 <= sat32(rnd(-wide_t'(pzz), 29) + rnd(-wide_t'(pxx), 29));
      sq2.d2 <= sat32(rnd(-wide_t'(pyy), 29) + rnd(-wide_t'(pxx), 29));
      sq2.xy <= sat32(rnd(wide_t'(pxy), 29));
      sq2.xz <= sat32(rnd(wide_t'(pxz), 29));
      sq2.yz <= sat32(rnd(wide_t'(pyz), 29));
      a0_2 <= sat32(rnd(wide_t'(k0a), 29) + rnd(wide_t'(k0b), 29));
      a1_2 <= sat32(rnd(wide_t'(k1a), 29) + rnd(wide_t'(k1b), 29));
      a2_2 <= sat32(rnd(wide_t'(k2a), 29) + rnd(wide_t'(k2b), 29));

      // [w]^2 v products
      tw3  <= tw2;
      s3   <= s2;
      c3   <= c2;
      sq3  <= sq2;
      a0_3 <= a0_2;
      a1_3 <= a1_2;
      a2_3 <= a2_2;
      bp00 <= sq2.d0 * tw2.lin_x;
      bp01 <= sq2.xy * tw2.lin_y;
      bp02 <= sq2.xz * tw2.lin_z;
      bp10 <= sq2.xy * tw2.lin_x;
      bp11 <= sq2.d1 * tw2.lin_y;
      bp12 <= sq2.yz * tw2.lin_z;
      bp20 <= sq2.xz * tw2.lin_x;
      bp21 <= sq2.yz * tw2.lin_y;
      bp22 <= sq2.d2 * tw2.lin_z;

      out_m.tw <= tw3;
      out_m.s  <= s3;
      out_m.oc <= FX_ONE30 - c3;
      out_m.qs <= CW'(wide_t'(tw3.angle) - rnd(wide_t'(s3), 2));
      out_m.sq <= sq3;
      out_m.a0 <= a0_3;
      out_m.a1 <= a1_3;
      out_m.a2 <= a2_3;
      out_m.b0 <= sat32(rnd(wide_t'(bp00), 29) + rnd(wide_t'(bp01), 29)
                        + rnd(wide_t'(bp02), 29));
      out_m.b1 <= sat32(rnd(wide_t'(bp10), 29) + rnd(wide_t'(bp11), 29)
                        + rnd(wide_t'(bp12), 29));
      out_m.b2 <= sat32(rnd(wide_t'(bp20), 29) + rnd(wide_t'(bp21), 29)
                        + rnd(wide_t'(bp22), 29));
    end
  end

endmodule

// ===== hdl/tet_fin.sv =====
`timescale 1ns / 1ps
module tet_fin import tet_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_vld,
  input  mat_t   in_m,
  output logic   out_vld,
  output xform_t out_x
);

  logic v1;
  logic signed [68:0] sk01, sk02, sk10, sk12, sk20, sk21;
  logic signed [68:0] od0, od1, od2, oxy, oxz, oyz;
  logic signed [68:0] qv0, qv1, qv2, oa0, oa1, oa2, qb0, qb1, qb2;
  logic signed [32:0] nwx, nwy, nwz;

  assign nwx = -33'(in_m.tw.axis_x);
  assign nwy = -33'(in_m.tw.axis_y);
  assign nwz = -33'(in_m.tw.axis_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      out_vld <= v1;
    end
    if (en) begin
      sk01 <= in_m.s * nwz;
      sk02 <= in_m.s * in_m.tw.axis_y;
      sk10 <= in_m.s * in_m.tw.axis_z;
      sk12 <= in_m.s * nwx;
      sk20 <= in_m.s * nwy;
      sk21 <= in_m.s * in_m.tw.axis_x;
      od0  <= in_m.oc * in_m.sq.d0;
      od1  <= in_m.oc * in_m.sq.d1;
      od2  <= in_m.oc * in_m.sq.d2;
      oxy  <= in_m.oc * in_m.sq.xy;
      oxz  <= in_m.oc * in_m.sq.xz;
      oyz  <= in_m.oc * in_m.sq.yz;
      qv0  <= in_m.tw.angle * in_m.tw.lin_x;
      qv1  <= in_m.tw.angle * in_m.tw.lin_y;
      qv2  <= in_m.tw.angle * in_m.tw.lin_z;
      oa0  <= in_m.oc * in_m.a0;
      oa1  <= in_m.oc * in_m.a1;
      oa2  <= in_m.oc * in_m.a2;
      qb0  <= in_m.qs * in_m.b0;
      qb1  <= in_m.qs * in_m.b1;
      qb2  <= in_m.qs * in_m.b2;

      out_x.rot_00 <= sat32(FX_ONE29 + rnd(wide_t'(od0), 30));
      out_x.rot_01 <= sat32(rnd(wide_t'(sk01), 30) + rnd(wide_t'(oxy), 30));
      out_x.rot_02 <= sat32(rnd(wide_t'(sk02), 30) + rnd(wide_t'(oxz), 30));
      out_x.rot_10 <= sat32(rnd(wide_t'(sk10), 30) + rnd(wide_t'(oxy), 30));
      out_x.rot_11 <= sat32(FX_ONE29 + rnd(wide_t'(od1), 30));
      out_x.rot_12 <= sat32(rnd(wide_t'(sk12), 30) + rnd(wide_t'(oyz), 30));
      out_x.rot_20 <= sat32(rnd(wide_t'(sk20), 30) + rnd(wide_t'(oxz), 30));
      out_x.rot_21 <= sat32(rnd(wide_t'(sk21), 30) + rnd(wide_t'(oyz), 30));
      out_x.rot_22 <= sat32(FX_ONE29 + rnd(wide_t'(od2), 30));
      out_x.pos_x  <= sat32(rnd(wide_t'(qv0), 28) + rnd(wide_t'(oa0), 30)
                            + rnd(wide_t'(qb0), 28));
      out_x.pos_y  <= sat32(rnd(wide_t'(qv1), 28) + rnd(wide_t'(oa1), 30)
                            + rnd(wide_t'(qb1), 28));
      out_x.pos_z  <= sat32(rnd(wide_t'(qv2), 28) + rnd(wide_t'(oa2), 30)
                            + rnd(wide_t'(qb2), 28));
    end
  end

endmodule
